// ===== rtl/tsplit_pkg.sv =====
// ----------------------------------------------------------------------------
// tsplit_pkg
// Types and fixed geometry constants shared by the track request splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package tsplit_pkg;

	// field widths
	localparam int unsigned LBA_W = 16;
	localparam int unsigned CNT_W = 11;
	localparam int unsigned CYL_W = 11;
	localparam int unsigned SEC_W = 5;
	localparam int unsigned OFS_W = 10;

	// disk geometry and request limits
	localparam int unsigned SECTORS_PER_TRACK = 18;
	localparam int unsigned HEADS             = 2;
	localparam int unsigned TRACK_SECTORS     = HEADS * SECTORS_PER_TRACK;
	localparam int unsigned MAX_REQUEST       = 1024;
	localparam int unsigned MAX_RESULTS       = 58;

	localparam int unsigned TRK_W = $clog2(TRACK_SECTORS);
	localparam int unsigned RES_W = $clog2(MAX_RESULTS + 1);

	// request kinds
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_SPLIT
	} tsplit_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

`default_nettype wire

// ===== rtl/tsplit_req_if.sv =====
// ----------------------------------------------------------------------------
// tsplit_req_if
// Request channel: one read or write request per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsplit_req_if;
	import tsplit_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     op;
	logic                     drive;
	logic [LBA_W-1:0]         start_block;
	logic [CNT_W-1:0]         block_count;

	modport source (output valid, output op, output drive, output start_block,
		output block_count, input ready);
	modport sink (input valid, input op, input drive, input start_block,
		input block_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/tsplit_chunk_if.sv =====
// ----------------------------------------------------------------------------
// tsplit_chunk_if
// Chunk channel: one track-aligned piece of a request per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsplit_chunk_if;
	import tsplit_pkg::*;

	logic             valid;
	logic             ready;
	logic [CYL_W-1:0] cylinder;
	logic             head;
	logic [SEC_W-1:0] first_sector;
	logic [SEC_W-1:0] chunk_sectors;
	logic [OFS_W-1:0] request_offset;
	logic             fetch_track;
	logic             store_track;
	logic             last;

	modport source (output valid, output cylinder, output head, output first_sector,
		output chunk_sectors, output request_offset, output fetch_track,
		output store_track, output last, input ready);
	modport sink (input valid, input cylinder, input head, input first_sector,
		input chunk_sectors, input request_offset, input fetch_track,
		input store_track, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/tsplit_div.sv =====
// ----------------------------------------------------------------------------
// tsplit_div
// Two-step divider of a block address by the sectors per cylinder.
// ----------------------------------------------------------------------------
`default_nettype none

module tsplit_div (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire [tsplit_pkg::LBA_W-1:0]  dividend,
	output tsplit_pkg::div_status_t      status,
	output logic [tsplit_pkg::CYL_W-1:0] quotient,
	output logic [tsplit_pkg::TRK_W-1:0] remainder
);
	import tsplit_pkg::*;

	// (x * ceil(2^21 / 36)) >> 21 equals x / 36 for every 16-bit block address
	localparam int unsigned      RECIP_SHIFT = 21;
	localparam logic [LBA_W-1:0] RECIP       =
		LBA_W'((2 ** RECIP_SHIFT + TRACK_SECTORS - 1) / TRACK_SECTORS);

	logic [LBA_W-1:0]   num_q;
	logic [CYL_W-1:0]   quot_q;
	logic [TRK_W-1:0]   rem_q;
	logic               step_q;
	logic               busy_q;
	logic               done_q;

	logic [2*LBA_W-1:0] product;
	logic [LBA_W-1:0]   back;
	logic [LBA_W-1:0]   rem_full;

	always_comb begin
		product  = {{LBA_W{1'b0}}, num_q} * {{LBA_W{1'b0}}, RECIP};
		back     = {{(LBA_W-CYL_W){1'b0}}, quot_q} * LBA_W'(TRACK_SECTORS);
		rem_full = num_q - back;
	end

	// first step takes the quotient, second step the remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= 1'b0;
		end else if (busy_q) begin
			step_q <= 1'b1;
			if (step_q) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
		end else if (busy_q && !step_q) begin
			quot_q <= product[RECIP_SHIFT +: CYL_W];
		end else if (busy_q) begin
			rem_q <= rem_full[TRK_W-1:0];
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quot_q;
	assign remainder   = rem_q;

endmodule

`default_nettype wire

// ===== rtl/track_request_splitter.sv =====
// ----------------------------------------------------------------------------
// track_request_splitter
// Splits sector requests into track-aligned chunks with a per-drive track cache.
// ----------------------------------------------------------------------------
// usage:
//   req carries one read or write request (op, drive, start_block, block_count)
//   per item; chunk returns one item per track touched, in address order, with
//   last set on the final one. a zero count or an absent drive gives no chunks.
//   counts above 1024 are clipped to 1024.
// timing:
//   a request goes through a two-step reciprocal divider (quotient, then
//   remainder) and a step that loads cylinder, head and sector before its first
//   chunk reaches the output register. chunks then leave at one per cycle while
//   the receiver takes them; once the final chunk of a request is loaded, the
//   next request can be taken. req.ready is high only while no request is in
//   work; a request may be taken while the final chunk of the previous one
//   still waits in the output register.
// reset:
//   arst_n clears the sequencer, the output valid and every cache valid bit.
// stall:
//   when chunk.ready is low the chunk in the output register holds and splitting
//   pauses until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module track_request_splitter #(
	parameter int unsigned NUM_DRIVES = 2
) (
	input  wire             clk,
	input  wire             arst_n,
	tsplit_req_if.sink      req,
	tsplit_chunk_if.source  chunk
);
	import tsplit_pkg::*;

	localparam int unsigned DRV_W = (NUM_DRIVES > 1) ? $clog2(NUM_DRIVES) : 1;

	tsplit_state_t state_q, state_d;

	logic                 op_q;
	logic [DRV_W-1:0]     drv_idx_q;
	logic [CNT_W-1:0]     remain_q;
	logic [OFS_W-1:0]     offset_q;
	logic [CYL_W-1:0]     cyl_q;
	logic                 head_q;
	logic [SEC_W-1:0]     sec_q;
	logic [RES_W-1:0]     nres_q;

	logic [NUM_DRIVES-1:0] cache_valid_q;
	logic [CYL_W-1:0]      cache_cyl_q  [NUM_DRIVES];
	logic                  cache_head_q [NUM_DRIVES];

	logic                 out_valid_q;
	logic [CYL_W-1:0]     out_cyl_q;
	logic                 out_head_q;
	logic [SEC_W-1:0]     out_sec_q;
	logic [SEC_W-1:0]     out_cnt_q;
	logic [OFS_W-1:0]     out_ofs_q;
	logic                 out_fetch_q;
	logic                 out_store_q;
	logic                 out_last_q;

	logic                 accept;
	logic                 go;
	logic                 div_start;
	logic                 chunk_load;
	div_status_t          div_stat;
	logic [CYL_W-1:0]     div_quot;
	logic [TRK_W-1:0]     div_rem;

	logic [CNT_W-1:0]     req_count;
	logic [SEC_W-1:0]     avail;
	logic [CNT_W-1:0]     cnt;
	logic [CNT_W-1:0]     remain_next;
	logic                 hit;
	logic                 is_last;
	logic                 upper_head;

	tsplit_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (req.start_block),
		.status    (div_stat),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// ---- request intake ----
	assign accept = req.valid && req.ready;
	assign go = (req.block_count != '0) && (32'(req.drive) < NUM_DRIVES);
	assign req_count = (req.block_count > CNT_W'(MAX_REQUEST)) ?
		CNT_W'(MAX_REQUEST) : req.block_count;

	// ---- chunk arithmetic ----
	always_comb begin
		avail       = SEC_W'(SECTORS_PER_TRACK) - sec_q;
		cnt         = (remain_q < CNT_W'(avail)) ? remain_q : CNT_W'(avail);
		remain_next = remain_q - cnt;
		hit         = cache_valid_q[drv_idx_q] && (cache_cyl_q[drv_idx_q] == cyl_q) &&
			(cache_head_q[drv_idx_q] == head_q);
		is_last     = (remain_next == '0) || (nres_q == RES_W'(MAX_RESULTS - 1));
		upper_head  = div_rem >= TRK_W'(SECTORS_PER_TRACK);
	end

	// ---- sequencer ----
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && go) state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (div_stat.done) state_d = ST_SPLIT;
			end
			ST_SPLIT: begin
				if (chunk_load && is_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready  = 1'b0;
		div_start  = 1'b0;
		chunk_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				div_start = req.valid && go;
			end
			ST_SPLIT: begin
				chunk_load = !out_valid_q || chunk.ready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---- request context ----
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= req.op;
			drv_idx_q <= DRV_W'(req.drive);
			remain_q  <= req_count;
			offset_q  <= '0;
			nres_q    <= '0;
		end else if (state_q == ST_DIVIDE && div_stat.done) begin
			cyl_q  <= div_quot;
			head_q <= upper_head;
			sec_q  <= upper_head ? SEC_W'(div_rem - TRK_W'(SECTORS_PER_TRACK)) :
				SEC_W'(div_rem);
		end else if (chunk_load) begin
			remain_q <= remain_next;
			offset_q <= offset_q + OFS_W'(cnt);
			nres_q   <= nres_q + 1'b1;
			// a chunk that is not the last always runs to the track end
			sec_q    <= '0;
			head_q   <= !head_q;
			if (head_q) cyl_q <= cyl_q + 1'b1;
		end
	end

	// ---- track cache ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_valid_q <= '0;
		end else if (chunk_load) begin
			// a miss fills the entry; any write drops it
			cache_valid_q[drv_idx_q] <= (op_q != OP_WRITE);
		end
	end

	always_ff @(posedge clk) begin
		if (chunk_load && !hit) begin
			cache_cyl_q[drv_idx_q]  <= cyl_q;
			cache_head_q[drv_idx_q] <= head_q;
		end
	end

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (chunk_load) begin
			out_valid_q <= 1'b1;
		end else if (chunk.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chunk_load) begin
			out_cyl_q   <= cyl_q;
			out_head_q  <= head_q;
			out_sec_q   <= sec_q + 1'b1;
			out_cnt_q   <= SEC_W'(cnt);
			out_ofs_q   <= offset_q;
			out_fetch_q <= !hit;
			out_store_q <= (op_q == OP_WRITE);
			out_last_q  <= is_last;
		end
	end

	assign chunk.valid          = out_valid_q;
	assign chunk.cylinder       = out_cyl_q;
	assign chunk.head           = out_head_q;
	assign chunk.first_sector   = out_sec_q;
	assign chunk.chunk_sectors  = out_cnt_q;
	assign chunk.request_offset = out_ofs_q;
	assign chunk.fetch_track    = out_fetch_q;
	assign chunk.store_track    = out_store_q;
	assign chunk.last           = out_last_q;

	// ---- checks ----
	a_chunk_in_track: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_load |-> (cnt != '0) && (CNT_W'(sec_q) + cnt <= CNT_W'(SECTORS_PER_TRACK)))
		else $error("chunk crosses track end or is empty");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_load && is_last |=> state_q == ST_IDLE)
		else $error("sequencer not idle after last chunk");

	a_write_drops: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_load && op_q == OP_WRITE |=> !cache_valid_q[$past(drv_idx_q)])
		else $error("write left track cached");

	a_divide_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIVIDE |-> div_stat.busy || div_stat.done)
		else $error("divider idle during divide");

	a_split_work: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SPLIT |-> remain_q != '0)
		else $error("splitting with nothing left");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for track_request_splitter. Requests go in from a queue,
// each accepted request is split into expected chunks by a local copy of the
// per-drive track cache, and every chunk taken from the block is compared
// field by field. Both channels idle at random, and the chunk side holds off
// once for a long stretch so that the block backs up into the request side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import tsplit_pkg::*;

	localparam int unsigned DRIVES          = 2;
	localparam int unsigned RANDOM_REQUESTS = 150;
	localparam int unsigned QUIET_LIMIT     = 3000;
	localparam int unsigned HOLD_CYCLES     = 400;
	localparam int unsigned HOLD_AT_CHUNK   = 100;
	localparam int unsigned DRAIN_CYCLES    = 60;

	typedef struct packed {
		logic             op;
		logic             drive;
		logic [LBA_W-1:0] start_block;
		logic [CNT_W-1:0] block_count;
	} request_t;

	typedef struct packed {
		logic [CYL_W-1:0] cylinder;
		logic             head;
		logic [SEC_W-1:0] first_sector;
		logic [SEC_W-1:0] chunk_sectors;
		logic [OFS_W-1:0] request_offset;
		logic             fetch_track;
		logic             store_track;
		logic             last;
	} chunk_t;

	logic clk = 1'b0;
	logic arst_n;

	tsplit_req_if   req ();
	tsplit_chunk_if chunk ();

	track_request_splitter #(.NUM_DRIVES(DRIVES)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.chunk  (chunk)
	);

	always #2 clk = ~clk;

	request_t    requests_to_send [$];
	chunk_t      chunks_due [$];
	int unsigned requests_taken = 0;
	int unsigned chunks_seen    = 0;
	int unsigned mismatches     = 0;
	int unsigned quiet          = 0;
	int unsigned send_gap       = 0;
	int unsigned take_gap       = 0;
	int unsigned hold_left      = 0;
	bit          hold_done      = 1'b0;
	bit          req_taken      = 1'b0;
	bit          chunk_taken    = 1'b0;

	// local copy of the one-track cache per drive
	logic             track_valid [DRIVES] = '{default: 1'b0};
	logic [CYL_W-1:0] track_cyl [DRIVES];
	logic             track_head [DRIVES];

	task automatic report_bad(input string msg);
		$display("chunk %0d: %s", chunks_seen, msg);
		mismatches++;
	endtask

	function automatic int unsigned draw_wait(input bit calm);
		if (calm)
			return 0;
		case ($urandom_range(0, 3))
			0: return 0;
			1: return $urandom_range(1, 3);
			default: return $urandom_range(0, 18);
		endcase
	endfunction

	task automatic add_request(input logic op, input logic drive, input int unsigned lba,
		input int unsigned count);
		request_t r;
		r.op          = op;
		r.drive       = drive;
		r.start_block = LBA_W'(lba);
		r.block_count = CNT_W'(count);
		requests_to_send.push_back(r);
	endtask

	// cut one request into track-aligned chunks and walk the cache along
	task automatic split_request(input request_t r);
		int unsigned      blk, left, ofs, in_cyl, sec0, avail, cnt, n;
		logic [CYL_W-1:0] cyl;
		logic             hd, hit;
		chunk_t           c;
		blk  = 32'(r.start_block);
		left = 32'(r.block_count);
		ofs  = 0;
		n    = 0;
		if (32'(r.drive) >= DRIVES)
			return;
		if (left > MAX_REQUEST)
			left = MAX_REQUEST;
		while (left > 0 && n < MAX_RESULTS) begin
			in_cyl = blk % TRACK_SECTORS;
			cyl    = CYL_W'(blk / TRACK_SECTORS);
			hd     = 1'(in_cyl / SECTORS_PER_TRACK);
			sec0   = in_cyl % SECTORS_PER_TRACK;
			avail  = SECTORS_PER_TRACK - sec0;
			cnt    = (left < avail) ? left : avail;
			hit    = track_valid[r.drive] && track_cyl[r.drive] == cyl &&
				track_head[r.drive] == hd;
			if (!hit) begin
				track_valid[r.drive] = 1'b1;
				track_cyl[r.drive]   = cyl;
				track_head[r.drive]  = hd;
			end
			// a write always stores the track back and drops it
			if (r.op == OP_WRITE)
				track_valid[r.drive] = 1'b0;
			left = left - cnt;
			n++;
			c.cylinder       = cyl;
			c.head           = hd;
			c.first_sector   = SEC_W'(sec0 + 1);
			c.chunk_sectors  = SEC_W'(cnt);
			c.request_offset = OFS_W'(ofs);
			c.fetch_track    = !hit;
			c.store_track    = r.op;
			c.last           = (left == 0 || n == MAX_RESULTS);
			chunks_due.push_back(c);
			ofs = ofs + cnt;
			blk = blk + cnt;
		end
	endtask

	// request driver
	always @(negedge clk) begin : drive_requests
		request_t    nxt;
		logic        offer;
		int unsigned gap;
		if (!arst_n) begin
			req.valid       <= 1'b0;
			req.op          <= OP_READ;
			req.drive       <= 1'b0;
			req.start_block <= '0;
			req.block_count <= '0;
		end else begin
			offer = req.valid;
			gap   = send_gap;
			if (req_taken) begin
				offer = 1'b0;
				gap   = draw_wait((requests_taken / 30) % 3 == 2);
			end
			if (!offer) begin
				if (gap == 0 && requests_to_send.size() != 0) begin
					nxt = requests_to_send.pop_front();
					offer = 1'b1;
					req.op          <= nxt.op;
					req.drive       <= nxt.drive;
					req.start_block <= nxt.start_block;
					req.block_count <= nxt.block_count;
				end else if (gap != 0) begin
					gap = gap - 1;
				end
			end
			send_gap  <= gap;
			req.valid <= offer;
		end
	end

	// long hold-off on the chunk side, once
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && chunks_seen >= HOLD_AT_CHUNK) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// chunk receiver
	always @(negedge clk) begin : take_chunks
		int unsigned gap;
		if (!arst_n) begin
			chunk.ready <= 1'b0;
		end else begin
			gap = take_gap;
			if (chunk_taken)
				gap = draw_wait((chunks_seen / 80) % 3 == 1);
			else if (gap != 0)
				gap = gap - 1;
			take_gap    <= gap;
			chunk.ready <= (gap == 0) && (hold_left == 0);
		end
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin : watch_outputs
		request_t r;
		chunk_t   want;
		req_taken   <= arst_n && req.valid && req.ready;
		chunk_taken <= arst_n && chunk.valid && chunk.ready;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				r.op          = req.op;
				r.drive       = req.drive;
				r.start_block = req.start_block;
				r.block_count = req.block_count;
				split_request(r);
				requests_taken <= requests_taken + 1;
			end
			if (chunk.valid && chunk.ready) begin
				if (chunks_due.size() == 0) begin
					report_bad($sformatf("unexpected item, cylinder %0d head %0d sector %0d",
						chunk.cylinder, chunk.head, chunk.first_sector));
				end else begin
					want = chunks_due.pop_front();
					if (chunk.cylinder !== want.cylinder)
						report_bad($sformatf("cylinder %0d, expected %0d",
							chunk.cylinder, want.cylinder));
					if (chunk.head !== want.head)
						report_bad($sformatf("head %0d, expected %0d", chunk.head, want.head));
					if (chunk.first_sector !== want.first_sector)
						report_bad($sformatf("first_sector %0d, expected %0d",
							chunk.first_sector, want.first_sector));
					if (chunk.chunk_sectors !== want.chunk_sectors)
						report_bad($sformatf("chunk_sectors %0d, expected %0d",
							chunk.chunk_sectors, want.chunk_sectors));
					if (chunk.request_offset !== want.request_offset)
						report_bad($sformatf("request_offset %0d, expected %0d",
							chunk.request_offset, want.request_offset));
					if (chunk.fetch_track !== want.fetch_track)
						report_bad($sformatf("fetch_track %0d, expected %0d",
							chunk.fetch_track, want.fetch_track));
					if (chunk.store_track !== want.store_track)
						report_bad($sformatf("store_track %0d, expected %0d",
							chunk.store_track, want.store_track));
					if (chunk.last !== want.last)
						report_bad($sformatf("last %0d, expected %0d", chunk.last, want.last));
				end
				chunks_seen <= chunks_seen + 1;
			end
			if ((req.valid && req.ready) || (chunk.valid && chunk.ready)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	initial begin : run
		request_t         r;
		int unsigned      made, total, sel;
		logic [LBA_W-1:0] recent [DRIVES];
		arst_n = 1'b0;

		// directed: cache hits and misses, track and cylinder crossings, limits
		add_request(OP_READ,  1'b0, 0,     1);
		add_request(OP_READ,  1'b0, 1,     17);
		add_request(OP_READ,  1'b0, 0,     36);
		add_request(OP_WRITE, 1'b0, 18,    5);
		add_request(OP_READ,  1'b0, 18,    1);
		add_request(OP_READ,  1'b1, 100,   0);
		add_request(OP_WRITE, 1'b1, 500,   0);
		add_request(OP_READ,  1'b0, 17,    1024);
		add_request(OP_READ,  1'b1, 65535, 2047);
		add_request(OP_WRITE, 1'b1, 65000, 1025);
		add_request(OP_WRITE, 1'b0, 65535, 1);
		add_request(OP_WRITE, 1'b1, 35,    2);
		add_request(OP_READ,  1'b1, 35,    3);
		add_request(OP_READ,  1'b1, 36,    1);
		add_request(OP_READ,  1'b0, 720,   4);
		add_request(OP_READ,  1'b1, 720,   4);
		add_request(OP_READ,  1'b0, 721,   2);
		add_request(OP_WRITE, 1'b0, 724,   30);
		add_request(OP_READ,  1'b0, 0,     1023);
		add_request(OP_WRITE, 1'b1, 71,    18);

		// random: mostly requests near the previous one on the same drive
		recent[0] = '0;
		recent[1] = LBA_W'(1000);
		made = 0;
		while (made < RANDOM_REQUESTS) begin
			r.op    = 1'($urandom_range(0, 1));
			r.drive = 1'($urandom_range(0, 1));
			sel     = $urandom_range(0, 99);
			if (sel < 35) begin
				r.start_block = recent[r.drive];
				r.block_count = CNT_W'($urandom_range(1, 40));
			end else if (sel < 55) begin
				r.start_block = recent[r.drive] - LBA_W'($urandom_range(1, 20));
				r.block_count = CNT_W'($urandom_range(1, 20));
			end else if (sel < 80) begin
				r.start_block = LBA_W'($urandom_range(0, 65535));
				r.block_count = CNT_W'($urandom_range(1, 60));
			end else if (sel < 90) begin
				r.start_block = LBA_W'($urandom_range(0, 65535));
				r.block_count = CNT_W'($urandom_range(61, 1024));
			end else if (sel < 94) begin
				r.start_block = LBA_W'($urandom_range(0, 65535));
				r.block_count = CNT_W'($urandom_range(1025, 2047));
			end else begin
				r.start_block = LBA_W'($urandom_range(0, 65535));
				r.block_count = '0;
			end
			recent[r.drive] = r.start_block + LBA_W'(r.block_count);
			requests_to_send.push_back(r);
			if (r.block_count != '0)
				made++;
		end
		total = requests_to_send.size();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (requests_taken != total)
			@(posedge clk);
		while (chunks_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
